// File: rtl/semr_pkg.sv
// Package with types, constants and helper functions for the Sobel RGB edge unit.
package semr_pkg;
  localparam int MaxWidth = 1024;
  localparam int MaxHeight = 4096;
  localparam int ColW = $clog2(MaxWidth);
  localparam int RowW = $clog2(MaxHeight + 1);
  localparam int CfgW = 13;
  localparam int CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] RegFrameWidth = 1'b0;
  localparam logic [CfgIdxW-1:0] RegFrameHeight = 1'b1;
  localparam logic CmdPixel = 1'b0;
  localparam logic CmdDrain = 1'b1;

  typedef logic [23:0] pixel_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic last;
  } result_t;

  typedef struct packed {
    pixel_t top;
    pixel_t mid;
    pixel_t bot;
  } column_t;

  // Squared gradient of one channel from three columns.
  function automatic logic [17:0] grad_sq(input column_t l, input column_t m,
                                          input column_t r, input int sh);
    logic [9:0] lf, rt, tp, bt;
    logic signed [10:0] gx, gy;
    logic signed [21:0] px, py;
    logic [20:0] s;
    begin
      lf = 10'(l.top[sh+:8]) + {1'b0, l.mid[sh+:8], 1'b0} + 10'(l.bot[sh+:8]);
      rt = 10'(r.top[sh+:8]) + {1'b0, r.mid[sh+:8], 1'b0} + 10'(r.bot[sh+:8]);
      tp = 10'(l.top[sh+:8]) + {1'b0, m.top[sh+:8], 1'b0} + 10'(r.top[sh+:8]);
      bt = 10'(l.bot[sh+:8]) + {1'b0, m.bot[sh+:8], 1'b0} + 10'(r.bot[sh+:8]);
      gx = $signed({1'b0, rt}) - $signed({1'b0, lf});
      gy = $signed({1'b0, bt}) - $signed({1'b0, tp});
      px = gx * gx;
      py = gy * gy;
      s = px[20:0] + py[20:0];
      grad_sq = (s > 21'd65280) ? 18'h3FFFF : s[17:0];
    end
  endfunction

  // Four steps of the digit-by-digit square root; the state is {root, remainder}.
  function automatic logic [17:0] sqrt_steps(input logic [17:0] st, input logic [7:0] pairs);
    logic [7:0] root;
    logic [11:0] rem;
    logic [11:0] trial;
    begin
      root = st[17:10];
      rem = {2'b00, st[9:0]};
      for (int i = 3; i >= 0; i--) begin
        rem = {rem[9:0], pairs[2*i+:2]};
        trial = {2'b00, root, 2'b01};
        if (rem >= trial) begin
          rem = rem - trial;
          root = {root[6:0], 1'b1};
        end else begin
          root = {root[6:0], 1'b0};
        end
      end
      sqrt_steps = {root, rem[9:0]};
    end
  endfunction

  // Rounds the root up when the remainder exceeds it; saturated input maps to 255.
  function automatic logic [7:0] round_root(input logic [17:0] st, input logic sat);
    logic [7:0] root;
    logic [9:0] rem;
    begin
      root = st[17:10];
      rem = st[9:0];
      if (sat || (rem > {2'b00, root} && root == 8'd255)) round_root = 8'd255;
      else if (rem > {2'b00, root}) round_root = root + 8'd1;
      else round_root = root;
    end
  endfunction
endpackage

// File: rtl/semr_if.sv
// Valid/ready stream interfaces for the Sobel RGB edge unit.
interface semr_in_if;
  logic valid;
  logic ready;
  logic cmd;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  modport source(output valid, cmd, red_in, green_in, blue_in, input ready);
  modport sink(input valid, cmd, red_in, green_in, blue_in, output ready);
endinterface

interface semr_out_if;
  logic valid;
  logic ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic frame_last;
  modport source(output valid, red_out, green_out, blue_out, frame_last, input ready);
  modport sink(input valid, red_out, green_out, blue_out, frame_last, output ready);
endinterface

// File: rtl/semr_line_mem.sv
// Two line buffers for the rows above the current one, with registered reads.
module semr_line_mem
  import semr_pkg::*;
(
  input  logic            clk,
  input  logic            rd_en,
  input  logic [ColW-1:0] rd_addr,
  input  logic            wr_en,
  input  logic [ColW-1:0] wr_addr,
  input  pixel_t          wr_mid,
  input  pixel_t          wr_pix,
  output pixel_t          rd_up,
  output pixel_t          rd_mid
);
  pixel_t upper_mem [MaxWidth];
  pixel_t middle_mem [MaxWidth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      upper_mem[wr_addr] <= wr_mid;
      middle_mem[wr_addr] <= wr_pix;
    end
    if (rd_en) begin
      rd_up <= upper_mem[rd_addr];
      rd_mid <= middle_mem[rd_addr];
    end
  end
endmodule

// File: rtl/semr_mag.sv
// Three channel Sobel magnitude pipeline: squared gradients, then rounded root in two halves.
module semr_mag
  import semr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  column_t col_l,
  input  column_t col_m,
  input  column_t col_r,
  input  logic    in_last,
  output logic    out_valid,
  output result_t out_res
);
  logic [17:0] sq_r, sq_g, sq_b;
  logic sq_valid, sq_last;
  logic [17:0] hi_r, hi_g, hi_b;
  logic [7:0] lo_r, lo_g, lo_b;
  logic sat_r, sat_g, sat_b;
  logic hi_valid, hi_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid <= 1'b0;
      hi_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      sq_valid <= in_valid;
      hi_valid <= sq_valid;
      out_valid <= hi_valid;
    end
    sq_r <= grad_sq(col_l, col_m, col_r, 16);
    sq_g <= grad_sq(col_l, col_m, col_r, 8);
    sq_b <= grad_sq(col_l, col_m, col_r, 0);
    sq_last <= in_last;
    hi_r <= sqrt_steps('0, sq_r[15:8]);
    hi_g <= sqrt_steps('0, sq_g[15:8]);
    hi_b <= sqrt_steps('0, sq_b[15:8]);
    lo_r <= sq_r[7:0];
    lo_g <= sq_g[7:0];
    lo_b <= sq_b[7:0];
    sat_r <= (sq_r == 18'h3FFFF);
    sat_g <= (sq_g == 18'h3FFFF);
    sat_b <= (sq_b == 18'h3FFFF);
    hi_last <= sq_last;
    out_res <= '{red: round_root(sqrt_steps(hi_r, lo_r), sat_r),
                 green: round_root(sqrt_steps(hi_g, lo_g), sat_g),
                 blue: round_root(sqrt_steps(hi_b, lo_b), sat_b), last: hi_last};
  end
endmodule

// File: rtl/sobel_edge_magnitude_rgb_unit.sv
// Sobel RGB edge magnitude unit: the top level with sequencer, window and output queue.
// Items are taken one at a time: each accepted word reads both line buffers, then,
// while busy, shifts the 3x3 window and writes back; no word is accepted while busy.
// Results pass a three-stage magnitude pipeline into a small output queue; input
// is held off while the queue lacks room for the item's up to two results. The
// frame's final result has frame_last set; after the frame the host sends
// frame_width drain words.
module sobel_edge_magnitude_rgb_unit
  import semr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgW-1:0]    cfg_data,
  semr_in_if.sink            pix_in,
  semr_out_if.source         pix_out
);
  localparam int QDepth = 8;
  localparam int QW = $clog2(QDepth);

  logic [10:0] frame_width;
  logic [12:0] frame_height;
  logic [ColW-1:0] column_count;
  logic [RowW-1:0] row_count;
  logic busy;
  logic cur_cmd;
  pixel_t cur_pix;
  column_t win_m, win_r;
  pixel_t rd_up, rd_mid;
  logic [10:0] w_eff;
  logic [RowW-1:0] h_eff;

  logic [QW:0] q_count, pending;
  logic [QW-1:0] q_wr, q_rd;
  result_t q_mem [QDepth];

  logic accept;
  logic row_end, emit_a, emit_b;
  pixel_t up_val, mid_val, pix_val;
  column_t new_col, zero_col;
  logic m0_valid, m1_valid;
  logic m_last;
  logic m1_valid_out, m0_valid_out;
  result_t m0_res, m1_res;
  logic [QW:0] q_count_next;

  assign w_eff = (frame_width == 11'd0) ? 11'd1 :
                 (frame_width > 11'(MaxWidth)) ? 11'(MaxWidth) : frame_width;
  assign h_eff = (frame_height == 13'd0) ? RowW'(1) :
                 (frame_height > 13'(MaxHeight)) ? RowW'(MaxHeight) : RowW'(frame_height);

  assign accept = pix_in.valid && pix_in.ready;
  assign pix_in.ready = !rst && !busy && (q_count + pending <= (QW+1)'(QDepth - 2));

  semr_line_mem u_mem (
    .clk(clk), .rd_en(accept), .rd_addr(column_count),
    .wr_en(busy), .wr_addr(column_count),
    .wr_mid(mid_val), .wr_pix(pix_val), .rd_up(rd_up), .rd_mid(rd_mid)
  );

  always_comb begin
    up_val = (row_count >= RowW'(2)) ? rd_up : '0;
    mid_val = (row_count >= RowW'(1)) ? rd_mid : '0;
    pix_val = (cur_cmd == CmdPixel) ? cur_pix : '0;
    new_col = '{top: up_val, mid: mid_val, bot: pix_val};
    zero_col = '0;
    row_end = (11'(column_count) + 11'd1) >= w_eff;
    emit_a = busy && row_count >= RowW'(1) && column_count != '0;
    emit_b = busy && row_count >= RowW'(1) && row_end;
  end

  // Window after the shift; a new row starts from zero columns.
  column_t sh_l, sh_m;
  assign sh_l = (column_count == '0) ? zero_col : win_m;
  assign sh_m = (column_count == '0) ? zero_col : win_r;

  semr_mag u_mag_a (
    .clk(clk), .rst(rst), .in_valid(emit_a), .col_l(sh_l), .col_m(sh_m),
    .col_r(new_col), .in_last(1'b0), .out_valid(m0_valid_out), .out_res(m0_res)
  );
  semr_mag u_mag_b (
    .clk(clk), .rst(rst), .in_valid(emit_b), .col_l(sh_m), .col_m(new_col),
    .col_r(zero_col), .in_last(m_last), .out_valid(m1_valid_out), .out_res(m1_res)
  );
  assign m_last = row_count >= h_eff;
  assign m0_valid = m0_valid_out;
  assign m1_valid = m1_valid_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= 11'd1024;
      frame_height <= 13'd1024;
      column_count <= '0;
      row_count <= '0;
      busy <= 1'b0;
      win_m <= '0;
      win_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          RegFrameWidth: frame_width <= cfg_data[10:0];
          RegFrameHeight: frame_height <= cfg_data;
          default: ;
        endcase
      end
      busy <= accept;
      if (busy) begin
        win_m <= sh_m;
        win_r <= new_col;
        if (row_end) begin
          column_count <= '0;
          row_count <= (row_count >= h_eff) ? '0 : row_count + RowW'(1);
        end else begin
          column_count <= column_count + ColW'(1);
        end
      end
    end
    if (accept) begin
      cur_cmd <= pix_in.cmd;
      cur_pix <= {pix_in.red_in, pix_in.green_in, pix_in.blue_in};
    end
  end

  // Results in flight count against queue room.
  logic [1:0] new_pend, done_pend;
  logic [1:0] enq_n;
  logic out_take;
  assign new_pend = {1'b0, emit_a} + {1'b0, emit_b};
  assign done_pend = {1'b0, m0_valid} + {1'b0, m1_valid};
  assign enq_n = done_pend;
  assign out_take = pix_out.valid && pix_out.ready;
  assign q_count_next = q_count + (QW+1)'(enq_n) - (QW+1)'(out_take);

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
      q_count <= '0;
      q_wr <= '0;
      q_rd <= '0;
    end else begin
      pending <= pending + (QW+1)'(new_pend) + (QW+1)'(accept ? 2'd2 : 2'd0)
                 - (QW+1)'(done_pend) - (QW+1)'(busy ? 2'd2 : 2'd0);
      q_count <= q_count_next;
      if (out_take) q_rd <= q_rd + QW'(1);
      q_wr <= q_wr + QW'(enq_n);
    end
    if (m0_valid) q_mem[q_wr] <= m0_res;
    if (m1_valid) q_mem[m0_valid ? q_wr + QW'(1) : q_wr] <= m1_res;
  end

  assign pix_out.valid = q_count != '0;
  assign pix_out.red_out = q_mem[q_rd].red;
  assign pix_out.green_out = q_mem[q_rd].green;
  assign pix_out.blue_out = q_mem[q_rd].blue;
  assign pix_out.frame_last = q_mem[q_rd].last;
endmodule

// File: sim/sobel_edge_magnitude_rgb_unit_tb.sv
// Testbench for the Sobel RGB edge magnitude unit: streams small frames and checks every word.
`timescale 1ns / 100ps
module sobel_edge_magnitude_rgb_unit_tb;
  import semr_pkg::*;

  typedef struct packed {
    logic cmd;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_word_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgW-1:0] cfg_data;

  semr_in_if pix_in ();
  semr_out_if pix_out ();

  sobel_edge_magnitude_rgb_unit dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .pix_in(pix_in.sink),
    .pix_out(pix_out.source)
  );

  // Predictor state.
  int unsigned width_reg;
  int unsigned height_reg;
  logic [23:0] upper_line[MaxWidth];
  logic [23:0] middle_line[MaxWidth];
  logic [23:0] win[3][3];
  int unsigned col_pos;
  int unsigned row_pos;

  pixel_word_t pending_words[$];
  result_t expected_edges[$];

  int errors;
  int idle_cycles;
  int burst_left;
  int gap_left;
  bit sender_paused;
  bit stimulus_done;
  int unsigned accept_count;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [7:0] edge_mag(input logic [23:0] w[3][3], input int sh);
    int lf, rt, tp, bt, gx, gy, s, n;
    begin
      lf = w[0][0][sh+:8] + 2 * w[1][0][sh+:8] + w[2][0][sh+:8];
      rt = w[0][2][sh+:8] + 2 * w[1][2][sh+:8] + w[2][2][sh+:8];
      tp = w[0][0][sh+:8] + 2 * w[0][1][sh+:8] + w[0][2][sh+:8];
      bt = w[2][0][sh+:8] + 2 * w[2][1][sh+:8] + w[2][2][sh+:8];
      gx = rt - lf;
      gy = bt - tp;
      s = gx * gx + gy * gy;
      if (s > 65280) return 8'd255;
      n = 0;
      while ((n + 1) * (n + 1) <= s) n++;
      if (s > n * n + n) n++;
      return (n > 255) ? 8'd255 : 8'(n);
    end
  endfunction

  function automatic result_t edge_result(input logic [23:0] w[3][3], input logic last);
    result_t r;
    begin
      r.red = edge_mag(w, 16);
      r.green = edge_mag(w, 8);
      r.blue = edge_mag(w, 0);
      r.last = last;
      return r;
    end
  endfunction

  task automatic predict_edges(input pixel_word_t wd);
    int unsigned wv, hv, c, r;
    logic [23:0] px, up, md;
    logic [23:0] sh[3][3];
    bit row_end;
    begin
      wv = (width_reg == 0) ? 1 : ((width_reg > MaxWidth) ? MaxWidth : width_reg);
      hv = (height_reg == 0) ? 1 : ((height_reg > MaxHeight) ? MaxHeight : height_reg);
      c = col_pos % MaxWidth;
      r = row_pos;
      px = (wd.cmd == CmdPixel) ? {wd.red, wd.green, wd.blue} : 24'd0;
      if (c == 0)
        foreach (win[i, j]) win[i][j] = '0;
      up = (r >= 2) ? upper_line[c] : '0;
      md = (r >= 1) ? middle_line[c] : '0;
      for (int k = 0; k < 3; k++) begin
        win[k][0] = win[k][1];
        win[k][1] = win[k][2];
      end
      win[0][2] = up;
      win[1][2] = md;
      win[2][2] = px;
      upper_line[c] = md;
      middle_line[c] = px;
      if (r >= 1 && c >= 1) expected_edges.push_back(edge_result(win, 1'b0));
      row_end = (c + 1 >= wv);
      if (row_end && r >= 1) begin
        for (int k = 0; k < 3; k++) begin
          sh[k][0] = win[k][1];
          sh[k][1] = win[k][2];
          sh[k][2] = '0;
        end
        expected_edges.push_back(edge_result(sh, r >= hv));
      end
      if (row_end) begin
        col_pos = 0;
        row_pos = (r >= hv) ? 0 : r + 1;
      end else begin
        col_pos = c + 1;
      end
    end
  endtask

  // Driver.
  always @(posedge clk) begin
    if (rst) begin
      pix_in.valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (pix_in.valid && pix_in.ready) begin
        predict_edges(pixel_word_t'({pix_in.cmd, pix_in.red_in, pix_in.green_in,
                                     pix_in.blue_in}));
        accept_count <= accept_count + 1;
      end
      if (!pix_in.valid || pix_in.ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          pix_in.valid <= 1'b0;
        end else if (pending_words.size() > 0 && !sender_paused) begin
          pixel_word_t nw;
          nw = pending_words.pop_front();
          pix_in.valid <= 1'b1;
          pix_in.cmd <= nw.cmd;
          pix_in.red_in <= nw.red;
          pix_in.green_in <= nw.green;
          pix_in.blue_in <= nw.blue;
          if (burst_left > 0) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          pix_in.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor and receiver stall pattern.
  always @(posedge clk) begin
    if (rst) begin
      pix_out.ready <= 1'b0;
    end else begin
      if (pix_out.valid && pix_out.ready) begin
        if (expected_edges.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("Unexpected word: %0d %0d %0d last %0b", pix_out.red_out,
                     pix_out.green_out, pix_out.blue_out, pix_out.frame_last);
        end else begin
          result_t e;
          e = expected_edges.pop_front();
          if (e.red !== pix_out.red_out || e.green !== pix_out.green_out ||
              e.blue !== pix_out.blue_out || e.last !== pix_out.frame_last) begin
            errors++;
            if (errors <= 10)
              $display("Mismatch: expected %0d %0d %0d last %0b, got %0d %0d %0d last %0b",
                       e.red, e.green, e.blue, e.last, pix_out.red_out,
                       pix_out.green_out, pix_out.blue_out, pix_out.frame_last);
          end
        end
      end
      case (accept_count[9:8])
        2'd0: pix_out.ready <= 1'b1;
        2'd1: pix_out.ready <= ($urandom_range(0, 3) != 0);
        2'd2: pix_out.ready <= ($urandom_range(0, 1) != 0);
        default: pix_out.ready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    if (rst || (pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready) ||
        (pending_words.size() == 0 && expected_edges.size() == 0))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int unsigned val);
    begin
      cfg_we <= 1'b1;
      cfg_index <= idx;
      cfg_data <= CfgW'(val);
      @(posedge clk);
      cfg_we <= 1'b0;
      if (idx == RegFrameWidth) width_reg = val & 32'h7FF;
      else height_reg = val & 32'h1FFF;
    end
  endtask

  task automatic wait_drained();
    int guard;
    begin
      guard = 0;
      while ((pending_words.size() > 0 || pix_in.valid || expected_edges.size() > 0) &&
             guard < 200000) begin
        @(posedge clk);
        guard++;
      end
      repeat (20) @(posedge clk);
    end
  endtask

  function automatic pixel_word_t rand_pixel(input int mode);
    pixel_word_t p;
    begin
      p.cmd = CmdPixel;
      case (mode)
        0: {p.red, p.green, p.blue} = 24'h000000;
        1: {p.red, p.green, p.blue} = 24'hFFFFFF;
        2: {p.red, p.green, p.blue} = ($urandom_range(0, 1) != 0) ? 24'hFFFFFF : 24'h0;
        default: {p.red, p.green, p.blue} = 24'($urandom());
      endcase
      return p;
    end
  endfunction

  // Queue one frame plus its drain row; count of words queued is returned.
  function automatic int queue_frame(input int w, input int h, input int mode);
    pixel_word_t d;
    begin
      for (int i = 0; i < w * h; i++)
        pending_words.push_back(rand_pixel(mode == 4 ? $urandom_range(0, 3) : mode));
      for (int i = 0; i < w; i++) begin
        d.cmd = CmdDrain;
        {d.red, d.green, d.blue} = 24'($urandom());
        pending_words.push_back(d);
      end
      return w * h + w;
    end
  endfunction

  initial begin
    int sent;
    int w, h;
    pixel_word_t p;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    pix_in.valid = 1'b0;
    pix_in.cmd = CmdPixel;
    pix_in.red_in = '0;
    pix_in.green_in = '0;
    pix_in.blue_in = '0;
    pix_out.ready = 1'b0;
    errors = 0;
    sender_paused = 1'b0;
    accept_count = 0;
    width_reg = 1024;
    height_reg = 1024;
    col_pos = 0;
    row_pos = 0;
    foreach (win[i, j]) win[i][j] = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: a single pixel frame (width 0 and height 0 act as 1).
    write_reg(RegFrameWidth, 0);
    write_reg(RegFrameHeight, 0);
    sent = queue_frame(1, 1, 1);
    wait_drained();
    // Extremes of the channels, a drain inside the frame and an extra pixel in the drain row.
    write_reg(RegFrameWidth, 4);
    write_reg(RegFrameHeight, 3);
    for (int i = 0; i < 12; i++) begin
      p = rand_pixel((i % 3 == 0) ? 0 : 1);
      if (i == 5) p.cmd = CmdDrain;
      pending_words.push_back(p);
    end
    p = rand_pixel(1);
    pending_words.push_back(p);
    for (int i = 0; i < 3; i++) begin
      p.cmd = CmdDrain;
      pending_words.push_back(p);
    end
    sent += 16;
    wait_drained();

    // Oversized values are written to both registers, then a 2x2 frame is set and streamed.
    write_reg(RegFrameWidth, 2047);
    write_reg(RegFrameHeight, 8191);
    write_reg(RegFrameWidth, 2);
    write_reg(RegFrameHeight, 2);
    sent += queue_frame(2, 2, 2);
    wait_drained();

    // Random frames of small sizes, with an occasional long single row.
    while (sent < 950) begin
      if ($urandom_range(0, 9) == 0 && sent < 600) begin
        w = $urandom_range(64, 128);
        h = 1;
      end else begin
        w = $urandom_range(1, 12);
        h = $urandom_range(1, 8);
      end
      write_reg(RegFrameWidth, w);
      write_reg(RegFrameHeight, h);
      sent += queue_frame(w, h, 4);
      wait_drained();
    end

    // Sender streams part of one more frame, holds until every outstanding result has come out, then resumes.
    write_reg(RegFrameWidth, 5);
    write_reg(RegFrameHeight, 4);
    sender_paused = 1'b1;
    sent += queue_frame(5, 4, 3);
    sender_paused = 1'b0;
    repeat (30) @(posedge clk);
    sender_paused = 1'b1;
    while (expected_edges.size() > 0) @(posedge clk);
    sender_paused = 1'b0;
    wait_drained();

    if (errors == 0 && expected_edges.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

// File: filelist.f
rtl/semr_pkg.sv
rtl/semr_if.sv
rtl/semr_line_mem.sv
rtl/semr_mag.sv
rtl/sobel_edge_magnitude_rgb_unit.sv
sim/sobel_edge_magnitude_rgb_unit_tb.sv
